// ----- src/ibq_pkg.sv -----
// ----------------------------------------------------------------------------
// ibq_pkg
// shared constants, register codes and the result word type
// ----------------------------------------------------------------------------
package ibq_pkg;

  localparam int COORD_WIDTH_DEF   = 32;
  localparam int OUT_FRAC_BITS_DEF = 29;
  localparam int SQRT_GUARD        = 16;
  localparam int QLIM_LOG          = 62;
  localparam int ADDR_W            = 4;
  localparam int RES_W             = 32;

  localparam logic [15:0] COORD_TOL_RST  = 16'd8;
  localparam logic [15:0] WEIGHT_TOL_RST = 16'd1;
  localparam logic [31:0] AREA_THR_RST   = 32'd0;

  typedef enum logic [1:0] {
    REG_COORD_TOL  = 2'd0,
    REG_WEIGHT_TOL = 2'd1,
    REG_AREA_THR   = 2'd2
  } reg_idx_t;

  typedef struct packed {
    logic             ok;
    logic [RES_W-1:0] u_coord;
    logic [RES_W-1:0] v_coord;
    logic [RES_W-1:0] weight0;
    logic [RES_W-1:0] weight1;
    logic [RES_W-1:0] weight2;
    logic [RES_W-1:0] weight3;
  } res_t;

endpackage

// ----- src/ibq_if.sv -----
// ----------------------------------------------------------------------------
// ibq interfaces
// valid/ready channels for the query word and the result word
// ----------------------------------------------------------------------------
interface ibq_sample_if #(parameter int CW = 32);
  logic                 valid;
  logic                 ready;
  logic signed [CW-1:0] query_x;
  logic signed [CW-1:0] query_y;
  logic signed [CW-1:0] corner0_x;
  logic signed [CW-1:0] corner0_y;
  logic signed [CW-1:0] corner1_x;
  logic signed [CW-1:0] corner1_y;
  logic signed [CW-1:0] corner2_x;
  logic signed [CW-1:0] corner2_y;
  logic signed [CW-1:0] corner3_x;
  logic signed [CW-1:0] corner3_y;

  modport source (output valid, query_x, query_y, corner0_x, corner0_y, corner1_x,
                  corner1_y, corner2_x, corner2_y, corner3_x, corner3_y, input ready);
  modport sink (input valid, query_x, query_y, corner0_x, corner0_y, corner1_x,
                corner1_y, corner2_x, corner2_y, corner3_x, corner3_y, output ready);
endinterface

interface ibq_coords_if;
  logic               valid;
  logic               ready;
  logic               ok;
  logic signed [31:0] u_coord;
  logic signed [31:0] v_coord;
  logic signed [31:0] weight0;
  logic signed [31:0] weight1;
  logic signed [31:0] weight2;
  logic signed [31:0] weight3;

  modport source (output valid, ok, u_coord, v_coord, weight0, weight1, weight2, weight3,
                  input ready);
  modport sink (input valid, ok, u_coord, v_coord, weight0, weight1, weight2, weight3,
                output ready);
endinterface

// ----- src/inverse_bilinear_quad_coords.sv -----
// ----------------------------------------------------------------------------
// inverse_bilinear_quad_coords
// bilinear (u,v) and corner weights of a query point inside a quad
// ----------------------------------------------------------------------------
// Takes one query word per cycle while the skid word is empty and returns
// one result word per query, in order. SW is the root width of the
// discriminant square root (85 at the default 32-bit coordinates). The
// pipeline length is set by the square root, which resolves one root bit
// per stage, and by the four dividers, which resolve one quotient bit per
// stage. An output register with a skid word lets a new query in while a
// finished result still waits. The APB registers hold the snap tolerances
// and the area zero threshold and must only be written while the block is
// empty.
// ----------------------------------------------------------------------------
module inverse_bilinear_quad_coords
  import ibq_pkg::*;
#(
  parameter int COORD_WIDTH   = COORD_WIDTH_DEF,
  parameter int OUT_FRAC_BITS = OUT_FRAC_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  ibq_sample_if.sink         sample,
  ibq_coords_if.source       coords,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [ADDR_W-1:0]  paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  localparam int CW    = COORD_WIDTH;
  localparam int OFB   = OUT_FRAC_BITS;
  localparam int SG    = SQRT_GUARD;
  localparam int DLW   = CW + 1;
  localparam int PW    = 2 * DLW;
  localparam int AW    = PW + 1;
  localparam int HW    = (AW + 1) / 2;
  localparam int HIW   = AW - HW;
  localparam int PMW   = 2 * AW;
  localparam int PSW   = PMW + 1;
  localparam int DSW   = PMW + 4;
  localparam int RADW  = DSW - 1 + 2 * SG;
  localparam int SW    = (RADW + 1) / 2;
  localparam int RW    = 2 * SW;
  localparam int KW    = AW + 3;
  localparam int KSW   = KW + SG;
  localparam int DENW  = ((KSW > SW + 1) ? KSW : SW + 1) + 1;
  localparam int NUMW  = AW + 1 + SG + OFB;
  localparam int QW    = QLIM_LOG + 2;
  localparam int WH    = QW / 2;
  localparam int WPW   = 2 * QW;
  localparam int SIDEW = 1 + 2 * AW + 2 * KW;

  localparam logic signed [QW-1:0] ONE  = QW'(1) <<< OFB;
  localparam logic [WPW-1:0]       QLIM = WPW'(1) << QLIM_LOG;

  // ---------------------------------------------------------------- registers
  logic [15:0] coord_tol;
  logic [15:0] weight_tol;
  logic [31:0] area_thr;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      coord_tol  <= COORD_TOL_RST;
      weight_tol <= WEIGHT_TOL_RST;
      area_thr   <= AREA_THR_RST;
    end else if (psel && penable && pwrite) begin
      case (paddr[3:2])
        REG_COORD_TOL:  coord_tol  <= pwdata[15:0];
        REG_WEIGHT_TOL: weight_tol <= pwdata[15:0];
        REG_AREA_THR:   area_thr   <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_COORD_TOL:  prdata = {16'd0, coord_tol};
      REG_WEIGHT_TOL: prdata = {16'd0, weight_tol};
      REG_AREA_THR:   prdata = area_thr;
      default:        prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------- helpers
  function automatic logic [QW-1:0] mag_q(input logic signed [QW-1:0] x);
    return x[QW-1] ? QW'(-x) : QW'(x);
  endfunction

  function automatic logic signed [QW-1:0] snap_c(input logic signed [QW-1:0] x,
                                                   input logic [15:0] tol);
    logic signed [QW-1:0] y;
    y = x;
    if (mag_q(y) < QW'(tol)) y = '0;
    if (mag_q(y - ONE) < QW'(tol)) y = ONE;
    return y;
  endfunction

  function automatic logic [31:0] sat32(input logic signed [QW-1:0] x);
    logic [31:0] r;
    if (x > QW'(32'sh7fffffff)) r = 32'h7fffffff;
    else if (x < -QW'(33'sh080000000)) r = 32'h80000000;
    else r = x[31:0];
    return r;
  endfunction

  function automatic logic outside(input logic signed [QW-1:0] u,
                                   input logic signed [QW-1:0] v);
    return u < 0 || v < 0 || u > ONE || v > ONE;
  endfunction

  // ---------------------------------------------------------------- flow
  logic en;
  logic ob_v;
  logic sk_v;
  res_t ob;
  res_t sk;
  logic lv;
  res_t lres;

  assign en           = !sk_v;
  assign sample.ready = en;

  // stage 1: corner offsets from the query point
  logic                  v1;
  logic signed [DLW-1:0] dx [4];
  logic signed [DLW-1:0] dy [4];

  always_ff @(posedge clk) begin
    if (rst) v1 <= 1'b0;
    else if (en) v1 <= sample.valid;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dx[0] <= DLW'(sample.corner0_x) - DLW'(sample.query_x);
      dy[0] <= DLW'(sample.corner0_y) - DLW'(sample.query_y);
      dx[1] <= DLW'(sample.corner1_x) - DLW'(sample.query_x);
      dy[1] <= DLW'(sample.corner1_y) - DLW'(sample.query_y);
      dx[2] <= DLW'(sample.corner2_x) - DLW'(sample.query_x);
      dy[2] <= DLW'(sample.corner2_y) - DLW'(sample.query_y);
      dx[3] <= DLW'(sample.corner3_x) - DLW'(sample.query_x);
      dy[3] <= DLW'(sample.corner3_y) - DLW'(sample.query_y);
    end
  end

  // stage 2: cross products, areas A0 A1 A2 A3 B0 B1
  logic                 v2;
  logic signed [PW-1:0] pa [6];
  logic signed [PW-1:0] pb [6];

  always_ff @(posedge clk) begin
    if (rst) v2 <= 1'b0;
    else if (en) v2 <= v1;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pa[0] <= dx[0] * dy[1];  pb[0] <= dy[0] * dx[1];
      pa[1] <= dx[1] * dy[2];  pb[1] <= dy[1] * dx[2];
      pa[2] <= dx[2] * dy[3];  pb[2] <= dy[2] * dx[3];
      pa[3] <= dx[3] * dy[0];  pb[3] <= dy[3] * dx[0];
      pa[4] <= dx[3] * dy[1];  pb[4] <= dy[3] * dx[1];
      pa[5] <= dx[0] * dy[2];  pb[5] <= dy[0] * dx[2];
    end
  end

  // stage 3: areas
  logic                 v3;
  logic signed [AW-1:0] ar [6];

  always_ff @(posedge clk) begin
    if (rst) v3 <= 1'b0;
    else if (en) v3 <= v2;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int j = 0; j < 6; j++) ar[j] <= AW'(pa[j]) - AW'(pb[j]);
    end
  end

  // stage 4: partial products of B0^2, B1^2, A0 A2, A1 A3
  logic                 v4;
  logic [PMW-1:0]       pp4 [4][4];
  logic                 ng4 [4];
  logic signed [AW-1:0] kp4 [4];
  logic [AW-1:0]        ma4 [4];
  logic [AW-1:0]        mb4 [4];

  always_comb begin
    ma4[0] = ar[4][AW-1] ? AW'(-ar[4]) : AW'(ar[4]);
    mb4[0] = ma4[0];
    ma4[1] = ar[5][AW-1] ? AW'(-ar[5]) : AW'(ar[5]);
    mb4[1] = ma4[1];
    ma4[2] = ar[0][AW-1] ? AW'(-ar[0]) : AW'(ar[0]);
    mb4[2] = ar[2][AW-1] ? AW'(-ar[2]) : AW'(ar[2]);
    ma4[3] = ar[1][AW-1] ? AW'(-ar[1]) : AW'(ar[1]);
    mb4[3] = ar[3][AW-1] ? AW'(-ar[3]) : AW'(ar[3]);
  end

  always_ff @(posedge clk) begin
    if (rst) v4 <= 1'b0;
    else if (en) v4 <= v3;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int j = 0; j < 4; j++) begin
        pp4[j][0] <= PMW'(ma4[j][HW-1:0]) * PMW'(mb4[j][HW-1:0]);
        pp4[j][1] <= PMW'(ma4[j][HW-1:0]) * PMW'(mb4[j][AW-1:HW]);
        pp4[j][2] <= PMW'(ma4[j][AW-1:HW]) * PMW'(mb4[j][HW-1:0]);
        pp4[j][3] <= PMW'(ma4[j][AW-1:HW]) * PMW'(mb4[j][AW-1:HW]);
      end
      ng4[0] <= 1'b0;
      ng4[1] <= 1'b0;
      ng4[2] <= ar[0][AW-1] ^ ar[2][AW-1];
      ng4[3] <= ar[1][AW-1] ^ ar[3][AW-1];
      kp4[0] <= ar[0];
      kp4[1] <= ar[3];
      kp4[2] <= ar[4];
      kp4[3] <= ar[5];
    end
  end

  // stage 5: product sums
  logic                  v5;
  logic signed [PSW-1:0] pr5 [4];
  logic signed [AW-1:0]  kp5 [4];
  logic [PMW-1:0]        pm5 [4];

  always_comb begin
    for (int j = 0; j < 4; j++) begin
      pm5[j] = pp4[j][0] + ((pp4[j][1] + pp4[j][2]) << HW) + (pp4[j][3] << (2 * HW));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) v5 <= 1'b0;
    else if (en) v5 <= v4;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int j = 0; j < 4; j++) begin
        pr5[j] <= ng4[j] ? -PSW'(pm5[j]) : PSW'(pm5[j]);
        kp5[j] <= kp4[j];
      end
    end
  end

  // stage 6: discriminant and root-free denominator terms
  logic                  v6;
  logic signed [DSW-1:0] dsc;
  logic signed [AW-1:0]  a0_6;
  logic signed [AW-1:0]  a3_6;
  logic signed [KW-1:0]  k0_6;
  logic signed [KW-1:0]  k3_6;

  always_ff @(posedge clk) begin
    if (rst) v6 <= 1'b0;
    else if (en) v6 <= v5;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dsc  <= DSW'(pr5[0]) + DSW'(pr5[1]) + ((DSW'(pr5[2]) + DSW'(pr5[3])) <<< 1);
      a0_6 <= kp5[0];
      a3_6 <= kp5[1];
      k0_6 <= (KW'(kp5[0]) <<< 1) - KW'(kp5[2]) - KW'(kp5[3]);
      k3_6 <= (KW'(kp5[1]) <<< 1) + KW'(kp5[3]) - KW'(kp5[2]);
    end
  end

  // square root of the discriminant
  logic             ok6;
  logic [RW-1:0]    rad6;
  logic             vs;
  logic [SW-1:0]    root;
  logic [SIDEW-1:0] side_s;

  assign ok6  = !dsc[DSW-1];
  assign rad6 = ok6 ? (RW'(dsc[DSW-2:0]) << (2 * SG)) : '0;

  ibq_sqrt #(.SW(SW), .SIDE_W(SIDEW)) u_sqrt (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (v6),
    .radicand (rad6),
    .side_in  ({ok6, a0_6, a3_6, k0_6, k3_6}),
    .out_valid(vs),
    .root     (root),
    .side_out (side_s)
  );

  // stage 7: denominators, numerators, zero-area flags
  logic                  oks;
  logic signed [AW-1:0]  a0s;
  logic signed [AW-1:0]  a3s;
  logic signed [KW-1:0]  k0s;
  logic signed [KW-1:0]  k3s;
  logic signed [DENW-1:0] sx;

  assign {oks, a0s, a3s, k0s, k3s} = side_s;
  assign sx = signed'(DENW'(root));

  logic                   v7;
  logic                   ok7;
  logic                   zv7;
  logic                   zu7;
  logic signed [NUMW-1:0] nv7;
  logic signed [NUMW-1:0] nu7;
  logic signed [DENW-1:0] dvp7;
  logic signed [DENW-1:0] dvm7;
  logic signed [DENW-1:0] dup7;
  logic signed [DENW-1:0] dum7;
  logic [AW-1:0]          ma0;
  logic [AW-1:0]          ma3;

  assign ma0 = a0s[AW-1] ? AW'(-a0s) : AW'(a0s);
  assign ma3 = a3s[AW-1] ? AW'(-a3s) : AW'(a3s);

  always_ff @(posedge clk) begin
    if (rst) v7 <= 1'b0;
    else if (en) v7 <= vs;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ok7  <= oks;
      zv7  <= ma0 <= AW'(area_thr);
      zu7  <= ma3 <= AW'(area_thr);
      nv7  <= NUMW'(a0s) <<< (1 + SG + OFB);
      nu7  <= NUMW'(a3s) <<< (1 + SG + OFB);
      dvp7 <= (DENW'(k0s) <<< SG) + sx;
      dvm7 <= (DENW'(k0s) <<< SG) - sx;
      dup7 <= (DENW'(k3s) <<< SG) + sx;
      dum7 <= (DENW'(k3s) <<< SG) - sx;
    end
  end

  // dividers for both roots of u and v
  logic                 vdvp, vdvm, vdup, vdum;
  logic signed [QW-1:0] qvp, qvm, qup, qum;
  logic                 okd, zvd, zvd2, zud, zud2;

  ibq_div #(.NUMW(NUMW), .DENW(DENW), .SIDE_W(2)) u_div_vp (
    .clk(clk), .rst(rst), .en(en), .in_valid(v7), .num(nv7), .den(dvp7),
    .side_in({ok7, zv7}), .out_valid(vdvp), .quot(qvp), .side_out({okd, zvd})
  );

  ibq_div #(.NUMW(NUMW), .DENW(DENW), .SIDE_W(1)) u_div_vm (
    .clk(clk), .rst(rst), .en(en), .in_valid(v7), .num(nv7), .den(dvm7),
    .side_in(zv7), .out_valid(vdvm), .quot(qvm), .side_out(zvd2)
  );

  ibq_div #(.NUMW(NUMW), .DENW(DENW), .SIDE_W(1)) u_div_up (
    .clk(clk), .rst(rst), .en(en), .in_valid(v7), .num(nu7), .den(dup7),
    .side_in(zu7), .out_valid(vdup), .quot(qup), .side_out(zud)
  );

  ibq_div #(.NUMW(NUMW), .DENW(DENW), .SIDE_W(1)) u_div_um (
    .clk(clk), .rst(rst), .en(en), .in_valid(v7), .num(nu7), .den(dum7),
    .side_in(zu7), .out_valid(vdum), .quot(qum), .side_out(zud2)
  );

  // stage 8: zero-area override and coordinate snap
  logic                 v8, ok8;
  logic signed [QW-1:0] cv8, cu8, cva8, cua8;

  always_ff @(posedge clk) begin
    if (rst) v8 <= 1'b0;
    else if (en) v8 <= vdvp;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ok8  <= okd;
      cv8  <= snap_c(zvd  ? '0 : qvp, coord_tol);
      cva8 <= snap_c(zvd2 ? '0 : qvm, coord_tol);
      cu8  <= snap_c(zud  ? '0 : qup, coord_tol);
      cua8 <= snap_c(zud2 ? '0 : qum, coord_tol);
    end
  end

  // stage 9: root choice and weight factors
  logic                 v9, ok9, alt;
  logic signed [QW-1:0] u9, v9c, us, vs9;
  logic signed [QW-1:0] wa9 [4];
  logic signed [QW-1:0] wb9 [4];

  assign alt = outside(cu8, cv8) && !outside(cua8, cva8);
  assign us  = alt ? cua8 : cu8;
  assign vs9 = alt ? cva8 : cv8;

  always_ff @(posedge clk) begin
    if (rst) v9 <= 1'b0;
    else if (en) v9 <= v8;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ok9    <= ok8;
      u9     <= us;
      v9c    <= vs9;
      wa9[0] <= ONE - us;  wb9[0] <= ONE - vs9;
      wa9[1] <= us;        wb9[1] <= ONE - vs9;
      wa9[2] <= us;        wb9[2] <= vs9;
      wa9[3] <= ONE - us;  wb9[3] <= vs9;
    end
  end

  // stage 10: weight partial products
  logic                 v10, ok10;
  logic signed [QW-1:0] u10, v10c;
  logic [WPW-1:0]       wp10 [4][4];
  logic                 wn10 [4];
  logic [QW-1:0]        wma [4];
  logic [QW-1:0]        wmb [4];

  always_comb begin
    for (int j = 0; j < 4; j++) begin
      wma[j] = mag_q(wa9[j]);
      wmb[j] = mag_q(wb9[j]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) v10 <= 1'b0;
    else if (en) v10 <= v9;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ok10 <= ok9;
      u10  <= u9;
      v10c <= v9c;
      for (int j = 0; j < 4; j++) begin
        wp10[j][0] <= WPW'(wma[j][WH-1:0]) * WPW'(wmb[j][WH-1:0]);
        wp10[j][1] <= WPW'(wma[j][WH-1:0]) * WPW'(wmb[j][QW-1:WH]);
        wp10[j][2] <= WPW'(wma[j][QW-1:WH]) * WPW'(wmb[j][WH-1:0]);
        wp10[j][3] <= WPW'(wma[j][QW-1:WH]) * WPW'(wmb[j][QW-1:WH]);
        wn10[j]    <= wa9[j][QW-1] ^ wb9[j][QW-1];
      end
    end
  end

  // stage 11: weight products
  logic                 v11, ok11;
  logic signed [QW-1:0] u11, v11c;
  logic [WPW-1:0]       wm11 [4];
  logic                 wn11 [4];

  always_ff @(posedge clk) begin
    if (rst) v11 <= 1'b0;
    else if (en) v11 <= v10;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ok11 <= ok10;
      u11  <= u10;
      v11c <= v10c;
      for (int j = 0; j < 4; j++) begin
        wm11[j] <= wp10[j][0] + ((wp10[j][1] + wp10[j][2]) << WH) + (wp10[j][3] << (2 * WH));
        wn11[j] <= wn10[j];
      end
    end
  end

  // stage 12: rescale with rounding and clamp
  logic                 v12, ok12;
  logic signed [QW-1:0] u12, v12c;
  logic signed [QW-1:0] w12 [4];
  logic [WPW-1:0]       wr [4];
  logic [QW-1:0]        wc [4];

  always_comb begin
    for (int j = 0; j < 4; j++) begin
      wr[j] = (wm11[j] >> OFB) + WPW'(wm11[j][OFB-1]);
      wc[j] = (wr[j] > QLIM) ? QW'(QLIM) : QW'(wr[j]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) v12 <= 1'b0;
    else if (en) v12 <= v11;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ok12 <= ok11;
      u12  <= u11;
      v12c <= v11c;
      for (int j = 0; j < 4; j++) w12[j] <= wn11[j] ? -wc[j] : wc[j];
    end
  end

  // stage 13: weight snap and output saturation
  logic signed [QW-1:0] ws [4];

  always_comb begin
    for (int j = 0; j < 4; j++) begin
      if (mag_q(w12[j]) <= QW'(weight_tol)) ws[j] = '0;
      else if (mag_q(w12[j] - ONE) <= QW'(weight_tol)) ws[j] = ONE;
      else ws[j] = w12[j];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) lv <= 1'b0;
    else if (en) lv <= v12;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      lres.ok      <= ok12;
      lres.u_coord <= ok12 ? sat32(u12)   : '0;
      lres.v_coord <= ok12 ? sat32(v12c)  : '0;
      lres.weight0 <= ok12 ? sat32(ws[0]) : '0;
      lres.weight1 <= ok12 ? sat32(ws[1]) : '0;
      lres.weight2 <= ok12 ? sat32(ws[2]) : '0;
      lres.weight3 <= ok12 ? sat32(ws[3]) : '0;
    end
  end

  // output word and skid word
  always_ff @(posedge clk) begin
    if (rst) begin
      ob_v <= 1'b0;
      sk_v <= 1'b0;
    end else if (sk_v) begin
      if (coords.ready) begin
        ob   <= sk;
        sk_v <= 1'b0;
      end
    end else if (!ob_v || coords.ready) begin
      ob_v <= lv;
      ob   <= lres;
    end else if (lv) begin
      sk_v <= 1'b1;
      sk   <= lres;
    end
  end

  assign coords.valid   = ob_v;
  assign coords.ok      = ob.ok;
  assign coords.u_coord = ob.u_coord;
  assign coords.v_coord = ob.v_coord;
  assign coords.weight0 = ob.weight0;
  assign coords.weight1 = ob.weight1;
  assign coords.weight2 = ob.weight2;
  assign coords.weight3 = ob.weight3;

  // ---------------------------------------------------------------- checks
  a_div_lockstep: assert property (@(posedge clk) disable iff (rst)
    vdvp == vdvm && vdvp == vdup && vdvp == vdum)
    else $error("divider valids out of step");

  a_skid_fill: assert property (@(posedge clk) disable iff (rst)
    $rose(sk_v) |-> $past(ob_v && !coords.ready))
    else $error("skid word filled while output was free");

  a_no_root: assert property (@(posedge clk) disable iff (rst)
    coords.valid && !coords.ok |-> coords.u_coord == 0 && coords.v_coord == 0 &&
      coords.weight0 == 0 && coords.weight1 == 0 && coords.weight2 == 0 &&
      coords.weight3 == 0)
    else $error("result fields not cleared on negative discriminant");

endmodule

// ----- src/ibq_sqrt.sv -----
// ----------------------------------------------------------------------------
// ibq_sqrt
// pipelined integer square root, one root bit per stage
// ----------------------------------------------------------------------------
module ibq_sqrt
  import ibq_pkg::*;
#(
  parameter int SW     = 85,
  parameter int SIDE_W = 8
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                en,
  input  logic                in_valid,
  input  logic [2*SW-1:0]     radicand,
  input  logic [SIDE_W-1:0]   side_in,
  output logic                out_valid,
  output logic [SW-1:0]       root,
  output logic [SIDE_W-1:0]   side_out
);

  localparam int RW   = 2 * SW;
  localparam int REMW = SW + 2;

  logic              vld  [SW];
  logic [RW-1:0]     rad  [SW];
  logic [SW-1:0]     rt   [SW];
  logic [REMW-1:0]   rem  [SW];
  logic [SIDE_W-1:0] side [SW];

  for (genvar k = 0; k < SW; k++) begin : g_stage
    logic              v_prev;
    logic [RW-1:0]     rad_prev;
    logic [SW-1:0]     rt_prev;
    logic [REMW-1:0]   rem_prev;
    logic [SIDE_W-1:0] side_prev;
    logic [REMW-1:0]   rem_c;
    logic [REMW-1:0]   trial;
    logic              ge;

    if (k == 0) begin : g_first
      assign v_prev    = in_valid;
      assign rad_prev  = radicand;
      assign rt_prev   = '0;
      assign rem_prev  = '0;
      assign side_prev = side_in;
    end else begin : g_next
      assign v_prev    = vld[k-1];
      assign rad_prev  = rad[k-1];
      assign rt_prev   = rt[k-1];
      assign rem_prev  = rem[k-1];
      assign side_prev = side[k-1];
    end

    assign rem_c = {rem_prev[REMW-3:0], rad_prev[RW-1:RW-2]};
    assign trial = {rt_prev, 2'b01};
    assign ge    = rem_c >= trial;

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k] <= 1'b0;
      end else if (en) begin
        vld[k] <= v_prev;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rad[k]  <= rad_prev << 2;
        rt[k]   <= {rt_prev[SW-2:0], ge};
        rem[k]  <= ge ? rem_c - trial : rem_c;
        side[k] <= side_prev;
      end
    end
  end

  assign out_valid = vld[SW-1];
  assign root      = rt[SW-1];
  assign side_out  = side[SW-1];

endmodule

// ----- src/ibq_div.sv -----
// ----------------------------------------------------------------------------
// ibq_div
// pipelined signed divider, one quotient bit per stage, rounded to nearest
// and clamped to the coordinate limit
// ----------------------------------------------------------------------------
module ibq_div
  import ibq_pkg::*;
#(
  parameter int NUMW   = 113,
  parameter int DENW   = 87,
  parameter int SIDE_W = 1
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    en,
  input  logic                    in_valid,
  input  logic signed [NUMW-1:0]  num,
  input  logic signed [DENW-1:0]  den,
  input  logic [SIDE_W-1:0]       side_in,
  output logic                    out_valid,
  output logic signed [QLIM_LOG+1:0] quot,
  output logic [SIDE_W-1:0]       side_out
);

  localparam int QB   = QLIM_LOG + 1;
  localparam int OW   = QB + 1;
  localparam int CMPW = (NUMW > DENW + QB) ? NUMW : DENW + QB;
  localparam logic [OW-1:0] QLIM = OW'(1) << QLIM_LOG;

  // prep
  logic [NUMW-1:0] nm_c;
  logic [DENW-1:0] dm_c;
  logic            sat_c;
  logic            dz_c;

  assign nm_c  = num[NUMW-1] ? NUMW'(-num) : NUMW'(num);
  assign dm_c  = den[DENW-1] ? DENW'(-den) : DENW'(den);
  assign sat_c = (nm_c != '0) && (CMPW'(nm_c) >= (CMPW'(dm_c) << QB));
  assign dz_c  = (dm_c == '0) && (nm_c == '0);

  logic              vld  [QB+1];
  logic [DENW-1:0]   rem  [QB+1];
  logic [QB-1:0]     nlo  [QB+1];
  logic [QB-1:0]     q    [QB+1];
  logic [DENW-1:0]   dm   [QB+1];
  logic              neg  [QB+1];
  logic              sat  [QB+1];
  logic              dz   [QB+1];
  logic [SIDE_W-1:0] side [QB+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
    end else if (en) begin
      vld[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem[0]  <= DENW'(nm_c >> QB);
      nlo[0]  <= nm_c[QB-1:0];
      q[0]    <= '0;
      dm[0]   <= dm_c;
      neg[0]  <= num[NUMW-1] ^ den[DENW-1];
      sat[0]  <= sat_c;
      dz[0]   <= dz_c;
      side[0] <= side_in;
    end
  end

  for (genvar i = 0; i < QB; i++) begin : g_step
    logic [DENW:0] rc;
    logic          ge;

    assign rc = {rem[i], nlo[i][QB-1]};
    assign ge = rc >= {1'b0, dm[i]};

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[i+1] <= 1'b0;
      end else if (en) begin
        vld[i+1] <= vld[i];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem[i+1]  <= ge ? DENW'(rc - {1'b0, dm[i]}) : DENW'(rc);
        nlo[i+1]  <= nlo[i] << 1;
        q[i+1]    <= {q[i][QB-2:0], ge};
        dm[i+1]   <= dm[i];
        neg[i+1]  <= neg[i];
        sat[i+1]  <= sat[i];
        dz[i+1]   <= dz[i];
        side[i+1] <= side[i];
      end
    end
  end

  // rounding and clamp
  logic          rnd;
  logic [OW-1:0] qr;
  logic [OW-1:0] qm;

  assign rnd = {rem[QB], 1'b0} >= {1'b0, dm[QB]};
  assign qr  = OW'(q[QB]) + OW'(rnd);
  assign qm  = (sat[QB] || qr > QLIM) ? QLIM : qr;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= vld[QB];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      quot     <= dz[QB] ? '0 : (neg[QB] ? -qm : qm);
      side_out <= side[QB];
    end
  end

endmodule

// ----- tb/ibq_coords_checker.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ibq_coords_checker
// watches the query, result and register ports, works out the bilinear
// coordinates and weights of every accepted query with exact wide integer
// math and compares them in order with the result words
// ----------------------------------------------------------------------------
module ibq_coords_checker
  import ibq_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  ibq_sample_if             sample,
  ibq_coords_if             coords,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [31:0]       pwdata,
  input  logic              pready,
  output int                errors,
  output int                pending,
  output int                checked,
  output int                solved
);

  typedef logic signed [255:0] wide_t;
  typedef logic [255:0]        uwide_t;

  localparam longint ONE  = longint'(1) << OUT_FRAC_BITS_DEF;
  localparam longint QMAX = longint'(1) << QLIM_LOG;

  logic [15:0] coord_tol;
  logic [15:0] weight_tol;
  logic [31:0] area_thr;
  res_t        expected_coords[$];

  function automatic wide_t cross_area(input int qx, qy, ax, ay, bx, by);
    wide_t dax, day, dbx, dby;
    dax = ax; dax = dax - qx;
    day = ay; day = day - qy;
    dbx = bx; dbx = dbx - qx;
    dby = by; dby = dby - qy;
    return dax * dby - day * dbx;
  endfunction

  function automatic uwide_t isqrt(input uwide_t n);
    uwide_t r, b;
    r = '0;
    b = uwide_t'(1) << 254;
    while (b > n) b = b >> 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n = n - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic longint round_quot(input wide_t num, input wide_t den);
    uwide_t n, d, q, r;
    logic   neg;
    if (den == 0) begin
      if (num == 0) return 0;
      return (num < 0) ? -QMAX : QMAX;
    end
    neg = (num < 0) != (den < 0);
    n = (num < 0) ? uwide_t'(-num) : uwide_t'(num);
    d = (den < 0) ? uwide_t'(-den) : uwide_t'(den);
    q = n / d;
    r = n % d;
    if ((r << 1) >= d) q = q + 1;
    if (q > uwide_t'(QMAX)) q = uwide_t'(QMAX);
    return neg ? -longint'(q[63:0]) : longint'(q[63:0]);
  endfunction

  function automatic longint unsigned mag(input longint x);
    return (x < 0) ? longint'(0) - x : x;
  endfunction

  function automatic longint area_quot(input wide_t a, input wide_t e);
    wide_t aa, thr;
    aa  = (a < 0) ? -a : a;
    thr = {224'b0, area_thr};
    if (aa <= thr) return 0;
    return round_quot(a <<< (1 + SQRT_GUARD + OUT_FRAC_BITS_DEF), e);
  endfunction

  function automatic longint snap_coord(input longint x);
    longint unsigned tol;
    tol = coord_tol;
    if (mag(x) < tol) x = 0;
    if (mag(x - ONE) < tol) x = ONE;
    return x;
  endfunction

  function automatic logic [31:0] corner_weight(input longint a, input longint b);
    wide_t           wa, wb;
    longint          w;
    longint unsigned tol;
    wa  = a;
    wb  = b;
    tol = weight_tol;
    w   = round_quot(wa * wb, wide_t'(1) <<< OUT_FRAC_BITS_DEF);
    if (mag(w) <= tol) w = 0;
    else if (mag(w - ONE) <= tol) w = ONE;
    return sat32(w);
  endfunction

  function automatic logic [31:0] sat32(input longint x);
    if (x > 64'sd2147483647) x = 64'sd2147483647;
    if (x < -64'sd2147483648) x = -64'sd2147483648;
    return x[31:0];
  endfunction

  function automatic logic outside(input longint u, input longint v);
    return u < 0 || v < 0 || u > ONE || v > ONE;
  endfunction

  function automatic res_t solve_bilinear(input int qx, qy, x0, y0, x1, y1,
                                          x2, y2, x3, y3);
    res_t   r;
    wide_t  a0, a1, a2, a3, b0, b1, b3, disc, root, k0, k3;
    longint u, v, ua, va, t;
    r  = '0;
    a0 = cross_area(qx, qy, x0, y0, x1, y1);
    a1 = cross_area(qx, qy, x1, y1, x2, y2);
    a2 = cross_area(qx, qy, x2, y2, x3, y3);
    a3 = cross_area(qx, qy, x3, y3, x0, y0);
    b0 = cross_area(qx, qy, x3, y3, x1, y1);
    b1 = cross_area(qx, qy, x0, y0, x2, y2);
    b3 = cross_area(qx, qy, x2, y2, x0, y0);
    disc = b0 * b0 + b1 * b1 + ((a0 * a2 + a1 * a3) <<< 1);
    if (disc < 0) return r;
    root = isqrt(uwide_t'(disc) << (2 * SQRT_GUARD));
    k0 = ((a0 <<< 1) - b0 - b1) <<< SQRT_GUARD;
    k3 = ((a3 <<< 1) - b3 - b0) <<< SQRT_GUARD;
    v  = snap_coord(area_quot(a0, k0 + root));
    u  = snap_coord(area_quot(a3, k3 + root));
    va = snap_coord(area_quot(a0, k0 - root));
    ua = snap_coord(area_quot(a3, k3 - root));
    if (outside(u, v) && !outside(ua, va)) begin
      t = u; u = ua; ua = t;
      t = v; v = va; va = t;
    end
    r.ok      = 1'b1;
    r.u_coord = sat32(u);
    r.v_coord = sat32(v);
    r.weight0 = corner_weight(ONE - u, ONE - v);
    r.weight1 = corner_weight(u, ONE - v);
    r.weight2 = corner_weight(u, v);
    r.weight3 = corner_weight(ONE - u, v);
    return r;
  endfunction

  task automatic check_field(input string name, input logic [31:0] exp_v,
                             input logic [31:0] got_v);
    if (exp_v !== got_v) begin
      $error("%s expected %0d got %0d", name, $signed(exp_v), $signed(got_v));
      errors++;
    end
  endtask

  assign pending = expected_coords.size();

  always @(posedge clk) begin
    res_t exp_r;
    if (rst) begin
      coord_tol  <= COORD_TOL_RST;
      weight_tol <= WEIGHT_TOL_RST;
      area_thr   <= AREA_THR_RST;
      expected_coords.delete();
      errors  = 0;
      checked = 0;
      solved  = 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (reg_idx_t'(paddr[3:2]))
          REG_COORD_TOL:  coord_tol  <= pwdata[15:0];
          REG_WEIGHT_TOL: weight_tol <= pwdata[15:0];
          REG_AREA_THR:   area_thr   <= pwdata;
          default: ;
        endcase
      end
      if (sample.valid && sample.ready)
        expected_coords.push_back(solve_bilinear(
          sample.query_x, sample.query_y, sample.corner0_x, sample.corner0_y,
          sample.corner1_x, sample.corner1_y, sample.corner2_x, sample.corner2_y,
          sample.corner3_x, sample.corner3_y));
      if (coords.valid && coords.ready) begin
        if (expected_coords.size() == 0) begin
          $error("result word with no query outstanding");
          errors++;
        end else begin
          exp_r = expected_coords.pop_front();
          checked++;
          if (exp_r.ok) solved++;
          check_field("ok", {31'b0, exp_r.ok}, {31'b0, coords.ok});
          check_field("u_coord", exp_r.u_coord, coords.u_coord);
          check_field("v_coord", exp_r.v_coord, coords.v_coord);
          check_field("weight0", exp_r.weight0, coords.weight0);
          check_field("weight1", exp_r.weight1, coords.weight1);
          check_field("weight2", exp_r.weight2, coords.weight2);
          check_field("weight3", exp_r.weight3, coords.weight3);
        end
      end
    end
  end

endmodule

// ----- tb/inverse_bilinear_quad_coords_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// inverse_bilinear_quad_coords_tb
// drives directed and random quads and query points through the block under
// several register settings, with random gaps on both sides and one long
// result stall; the checker predicts and compares every result word
// ----------------------------------------------------------------------------
module inverse_bilinear_quad_coords_tb;
  import ibq_pkg::*;

  typedef logic [9:0][31:0] query_t;

  localparam int CYCLE_LIMIT = 600000;
  localparam int PHASE_ITEMS = 330;
  localparam int Q1          = 65536;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [31:0]       pwdata = '0;
  logic [31:0]       prdata;
  logic              pready;
  int                err_count, pend, checked, solved;
  int                cycles = 0;
  int                sent = 0;
  int                settings = 1;

  ibq_sample_if #(32) sample ();
  ibq_coords_if       coords ();

  inverse_bilinear_quad_coords dut (
    .clk(clk), .rst(rst), .sample(sample), .coords(coords),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  ibq_coords_checker chk (
    .clk(clk), .rst(rst), .sample(sample), .coords(coords),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .pready(pready), .errors(err_count), .pending(pend),
    .checked(checked), .solved(solved)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("inverse_bilinear_quad_coords verification failed");
      $finish;
    end
  end

  // result side: random stalls, a quiet stretch and one long hold-off
  initial begin
    int n, hold;
    n = 0;
    hold = 0;
    coords.ready = 1'b0;
    forever begin
      @(negedge clk);
      n++;
      if (n == 300) hold = 900;
      if (hold > 0) begin
        coords.ready = 1'b0;
        hold--;
      end else if (n > 1500 && n < 2300) begin
        coords.ready = 1'b1;
      end else begin
        coords.ready = ($urandom_range(99) >= 23);
      end
    end
  end

  task automatic send_query(input query_t w);
    while (!(sent > 300 && sent < 700) && $urandom_range(99) < 23) begin
      sample.valid = 1'b0;
      @(negedge clk);
    end
    sample.valid     = 1'b1;
    sample.query_x   = w[0];
    sample.query_y   = w[1];
    sample.corner0_x = w[2];
    sample.corner0_y = w[3];
    sample.corner1_x = w[4];
    sample.corner1_y = w[5];
    sample.corner2_x = w[6];
    sample.corner2_y = w[7];
    sample.corner3_x = w[8];
    sample.corner3_y = w[9];
    do @(posedge clk); while (!sample.ready);
    sent++;
    @(negedge clk);
    sample.valid = 1'b0;
  endtask

  task automatic write_reg(input reg_idx_t idx, input logic [31:0] value);
    @(negedge clk);
    psel    = 1'b1;
    pwrite  = 1'b1;
    penable = 1'b0;
    paddr   = {idx, 2'b00};
    pwdata  = value;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  task automatic set_regs(input logic [15:0] ct, input logic [15:0] wt,
                          input logic [31:0] at);
    wait (pend == 0);
    write_reg(REG_COORD_TOL, ct);
    write_reg(REG_WEIGHT_TOL, wt);
    write_reg(REG_AREA_THR, at);
    settings++;
  endtask

  function automatic query_t make_quad(input int x0, y0, x1, y1, x2, y2, x3, y3,
                                       input int qx, qy);
    return {y3, x3, y2, x2, y1, x1, y0, x0, qy, qx};
  endfunction

  // mostly plausible quads with a nearby query, the rest raw noise
  function automatic query_t random_query();
    query_t w;
    int bx, by, s, jit, k;
    k = $urandom_range(99);
    if (k < 15) begin
      foreach (w[i]) w[i] = $urandom;
      return w;
    end
    bx = $urandom_range(2097152) - 1048576;
    by = $urandom_range(2097152) - 1048576;
    s  = (k < 30) ? $urandom_range(64, 1) : $urandom_range(1 << 18, 256);
    jit = s / 4 + 1;
    w = make_quad(
      bx + $urandom_range(jit) - jit / 2, by + $urandom_range(jit) - jit / 2,
      bx + s + $urandom_range(jit) - jit / 2, by + $urandom_range(jit) - jit / 2,
      bx + s + $urandom_range(jit) - jit / 2, by + s + $urandom_range(jit) - jit / 2,
      bx + $urandom_range(jit) - jit / 2, by + s + $urandom_range(jit) - jit / 2,
      bx - s / 4 + $urandom_range(s + s / 2), by - s / 4 + $urandom_range(s + s / 2));
    if (k < 22) begin
      // bowtie: swap corners 2 and 3
      {w[7], w[6], w[9], w[8]} = {w[9], w[8], w[7], w[6]};
    end
    if (k >= 22 && k < 26) begin
      w[1] = w[0];
      w[3] = w[2];
    end
    return w;
  endfunction

  initial begin
    sample.valid = 1'b0;
    {sample.query_x, sample.query_y, sample.corner0_x, sample.corner0_y,
     sample.corner1_x, sample.corner1_y, sample.corner2_x, sample.corner2_y,
     sample.corner3_x, sample.corner3_y} = '0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    send_query(make_quad(0, 0, Q1, 0, Q1, Q1, 0, Q1, Q1 / 2, Q1 / 2));
    send_query(make_quad(0, 0, Q1, 0, Q1, Q1, 0, Q1, 0, 0));
    send_query(make_quad(0, 0, Q1, 0, Q1, Q1, 0, Q1, Q1, Q1));
    send_query(make_quad(0, 0, Q1, 0, Q1, Q1, 0, Q1, Q1, Q1 / 3));
    send_query(make_quad(0, 0, Q1, 0, Q1, Q1, 0, Q1, 3 * Q1, -2 * Q1));
    send_query(make_quad(0, 0, Q1, 0, 0, Q1, Q1, Q1, Q1 / 2, Q1 / 2));
    send_query(make_quad(0, 0, 4 * Q1, 0, 3 * Q1, Q1, Q1, Q1, 2 * Q1, Q1 / 2));
    send_query(make_quad(0, 0, Q1, 0, 2 * Q1, 0, 3 * Q1, 0, Q1, 0));
    send_query(make_quad(5, 5, 6, 5, 6, 6, 5, 6, 5, 6));
    send_query(make_quad(0, 0, 1, 0, 1, 1, 0, 1, 1, 0));
    send_query('0);
    send_query({10{32'h7FFFFFFF}});
    send_query({10{32'h80000000}});
    send_query({32'h7FFFFFFF, 32'h80000000, 32'h80000000, 32'h7FFFFFFF,
                32'h7FFFFFFF, 32'h7FFFFFFF, 32'h80000000, 32'h80000000,
                32'h00000000, 32'h00000000});
    send_query(make_quad(-2147483648, -2147483648, 2147483647, -2147483648,
                         2147483647, 2147483647, -2147483648, 2147483647, 0, 0));
    send_query(make_quad(0, 0, Q1, 0, Q1, Q1, 0, Q1, Q1 / 2, 2 * Q1));
    send_query({32'hFFFFFFFF, 32'h00000001, 32'hFFFF0000, 32'h0000FFFF,
                32'h55555555, 32'hAAAAAAAA, 32'hAAAAAAAA, 32'h55555555,
                32'h00010000, 32'hFFFF0000});
    send_query(make_quad(0, 0, Q1, 0, Q1, Q1, 0, Q1, Q1 - 3, 2));
    for (int i = 0; i < 3; i++) send_query(random_query());

    for (int p = 0; p < 5; p++) begin
      case (p)
        1: set_regs(16'd0, 16'd0, 32'd0);
        2: set_regs(16'hFFFF, 16'hFFFF, 32'hFFFFFFFF);
        3: set_regs($urandom_range(64), $urandom_range(16), $urandom_range(1 << 20));
        4: set_regs(COORD_TOL_RST, WEIGHT_TOL_RST, $urandom);
        default: ;
      endcase
      for (int i = 0; i < PHASE_ITEMS; i++) send_query(random_query());
    end

    wait (pend == 0);
    repeat (200) @(posedge clk);
    $display("%0d quads checked over %0d register settings, %0d with a real root",
             checked, settings, solved);
    if (err_count == 0) begin
      $display("inverse_bilinear_quad_coords verification clean");
    end else begin
      $display("inverse_bilinear_quad_coords verification failed");
    end
    $finish;
  end

endmodule
